// ===== rtl/atu_pkg.sv =====
// ----------------------------------------------------------------------------
// atu_pkg: shared types and constants of the ASCII-to-unsigned parser
// Holds the classified character beat, queue status and sizing constants.
// ----------------------------------------------------------------------------
package atu_pkg;

    // Limit of the consumed-character count (endptr offset saturates here)
    localparam int MAX_LEN = 1024;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int END_W   = 11;

    // Depth of the queue between classifier and parser
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Bases named by the prefix rules
    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    // One classified character beat
    typedef struct packed {
        logic       start;   // first character of a new string
        logic [5:0] radix;   // base sampled with start
        logic       blank;   // space, tab, CR, LF, FF, VT
        logic       minus;   // '-'
        logic       plus;    // '+'
        logic       zero;    // '0'
        logic       lx;      // lowercase 'x'
        logic       alnum;   // digit or letter
        logic [5:0] dval;    // digit value 0..35 when alnum
    } t_item;

    // Queue status seen by the front, the back and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/atu_front.sv =====
// ----------------------------------------------------------------------------
// atu_front: input beat acceptance and character classification
// Decodes each raw byte into character classes and a digit value.
// ----------------------------------------------------------------------------
module atu_front import atu_pkg::*; (
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_start,
    input  logic [5:0] i_radix,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_item      o_item
);

    // Accept a beat whenever the queue has room
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // Classify the character
    always_comb begin
        o_item.start = i_start;
        o_item.radix = i_radix;
        o_item.blank = (i_char inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h0B});
        o_item.minus = (i_char == 8'h2D);
        o_item.plus  = (i_char == 8'h2B);
        o_item.zero  = (i_char == 8'h30);
        o_item.lx    = (i_char == 8'h78);
        o_item.alnum = 1'b1;
        o_item.dval  = 6'd0;
        if (i_char inside {[8'h30:8'h39]}) begin
            o_item.dval = 6'(i_char - 8'h30);
        end else if (i_char inside {[8'h61:8'h7A]}) begin
            o_item.dval = 6'(i_char - 8'h61 + 8'd10);
        end else if (i_char inside {[8'h41:8'h5A]}) begin
            o_item.dval = 6'(i_char - 8'h41 + 8'd10);
        end else begin
            o_item.alnum = 1'b0;
        end
    end

endmodule

// ===== rtl/atu_queue.sv =====
// ----------------------------------------------------------------------------
// atu_queue: short register queue of classified beats
// Decouples the classifier from the parser so each side stalls on its own.
// ----------------------------------------------------------------------------
module atu_queue import atu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_qstat
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               do_push, do_pop;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/atu_back.sv =====
// ----------------------------------------------------------------------------
// atu_back: parse state machine, digit accumulation and output register
// Steps the prefix/sign/digit phases once per beat and holds the result.
// ----------------------------------------------------------------------------
module atu_back import atu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  t_qstat           i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_value,
    output logic             o_finished,
    output logic [END_W-1:0] o_end_index
);

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_ZDET   = 3'd2;
    localparam logic [2:0] PH_HEXZ   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]        r_phase, n_phase;
    logic              r_neg,   n_neg;
    logic [5:0]        r_base,  n_base;
    logic [31:0]       r_acc,   n_acc;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic              r_ovalid;
    logic [31:0]       r_value;
    logic              r_fin;
    logic [END_W-1:0]  r_end;
    logic              go;
    logic              bump;

    // Pop a beat when the output slot is free or being taken
    assign o_pop = !i_qstat.empty && (!r_ovalid || i_ready);

    // Step the parser for the head beat
    always_comb begin
        n_phase = i_item.start ? PH_LEAD : r_phase;
        n_neg   = i_item.start ? 1'b0    : r_neg;
        n_base  = i_item.start ? i_item.radix : r_base;
        n_acc   = i_item.start ? '0      : r_acc;
        n_cnt   = i_item.start ? '0      : r_cnt;
        go      = 1'b1;
        bump    = 1'b0;

        if (n_phase == PH_LEAD) begin
            if (i_item.blank) begin
                bump = 1'b1;
                go   = 1'b0;
            end else if (i_item.minus) begin
                n_neg   = 1'b1;
                bump    = 1'b1;
                n_phase = PH_PREFIX;
                go      = 1'b0;
            end else if (i_item.plus) begin
                bump    = 1'b1;
                n_phase = PH_PREFIX;
                go      = 1'b0;
            end else begin
                n_phase = PH_PREFIX;
            end
        end

        // Base detection and hex prefix
        if (go && n_phase == PH_PREFIX) begin
            if (n_base == BASE_AUTO) begin
                if (i_item.zero) begin
                    bump    = 1'b1;
                    n_phase = PH_ZDET;
                    go      = 1'b0;
                end else begin
                    n_base = BASE_DEC;
                end
            end else if (n_base == BASE_HEX && i_item.zero) begin
                bump    = 1'b1;
                n_phase = PH_HEXZ;
                go      = 1'b0;
            end
            if (go) begin
                n_phase = PH_DIGITS;
            end
        end

        if (go && n_phase == PH_ZDET) begin
            n_phase = PH_DIGITS;
            if (i_item.lx) begin
                n_base = BASE_HEX;
                bump   = 1'b1;
                go     = 1'b0;
            end else begin
                n_base = BASE_OCT;
            end
        end

        if (go && n_phase == PH_HEXZ) begin
            n_phase = PH_DIGITS;
            if (i_item.lx) begin
                bump = 1'b1;
                go   = 1'b0;
            end
        end

        // Accumulate a digit or end the number
        if (go && n_phase == PH_DIGITS) begin
            if (i_item.alnum && i_item.dval < n_base) begin
                n_acc = 32'(n_acc * {26'd0, n_base}) + {26'd0, i_item.dval};
                bump  = 1'b1;
            end else begin
                n_phase = PH_DONE;
            end
        end

        // Saturate the consumed count
        if (bump && n_cnt < CNT_W'(MAX_LEN)) begin
            n_cnt = n_cnt + 1'b1;
        end
    end

    // Hold parser state across beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_pop) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_value <= n_neg ? (32'd0 - n_acc) : n_acc;
            r_fin   <= (n_phase >= PH_DONE);
            r_end   <= END_W'(n_cnt);
        end
    end

    assign o_valid     = r_ovalid;
    assign o_value     = r_value;
    assign o_finished  = r_fin;
    assign o_end_index = r_end;

endmodule

// ===== rtl/ascii_to_unsigned_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser: streaming string-to-unsigned converter
// Flow: a character beat is written into the queue, then parsed into the output register.
// Throughput: one character per cycle while results are taken, set by the
// combinational 32x6 multiply-add in the parser stage; a two-entry queue decouples the sides.
// Reset: synchronous, active low; clears queue and output valid, parser goes to the
// finished phase with accumulator 0 and consumed count 0.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser import atu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // character[7:0], radix[13:8], zero pad
    input  logic        i_s_axis_tuser,  // start_req[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // value[31:0], end_index[42:32], zero pad
    output logic        o_m_axis_tuser   // finished[0]
);

    t_item            front_item;
    t_item            head_item;
    t_qstat           qstat;
    logic             push;
    logic             pop;
    logic [31:0]      value;
    logic             finished;
    logic [END_W-1:0] end_index;

    // Classify incoming beats
    atu_front u_front (
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_char  (i_s_axis_tdata[7:0]),
        .i_start (i_s_axis_tuser),
        .i_radix (i_s_axis_tdata[13:8]),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (front_item)
    );

    // Queue classified beats
    atu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    // Parse and drive results
    atu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_value     (value),
        .o_finished  (finished),
        .o_end_index (end_index)
    );

    assign o_m_axis_tdata = {5'd0, end_index, value};
    assign o_m_axis_tuser = finished;

    // Queue cannot be full and empty at once
    a_qstat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    // No result beat right after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid after reset");

    // Empty queue and free output slot leave no result next cycle
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.empty && (!o_m_axis_tvalid || i_m_axis_tready) |=> !o_m_axis_tvalid)
        else $error("result beat without a queued character");

    // End index never passes the saturation limit
    a_end_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (int'(end_index) <= MAX_LEN))
        else $error("end index above limit");

endmodule
